// ===== hw/rtl/gns_pkg.sv =====
// Shared types, constants and codes for the neighborhood satisfaction block.
package gns_pkg;

    localparam int MaxWidth  = 128;
    localparam int MaxHeight = 128;
    localparam int MaxRadius = 7;
    localparam int MaxTypes  = 7;
    localparam int Cells     = MaxWidth * MaxHeight;
    localparam int AddrW     = $clog2(Cells);
    localparam int CoordW    = 8;

    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_EVAL   = 2'd1;
    localparam logic [1:0] KIND_MOVE   = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    localparam logic [1:0] CFG_WIDTH     = 2'd0;
    localparam logic [1:0] CFG_HEIGHT    = 2'd1;
    localparam logic [1:0] CFG_RADIUS    = 2'd2;
    localparam logic [1:0] CFG_THRESHOLD = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [13:0] location;
        logic [13:0] target;
        logic [2:0]  cell_value;
    } item_t;

    typedef struct packed {
        logic [1:0] status;
        logic       moved;
        logic [7:0] score;
        logic [6:0] neighbor_count;
        logic       satisfied;
    } result_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV, S_CHECK, S_RDSRC, S_WAITSRC, S_RDTGT, S_WAITTGT,
        S_SCAN, S_LAST, S_CMP, S_MULT, S_DONE, S_WRMOVE
    } state_t;

    // memory access request from sequencer
    typedef struct packed {
        logic             we;
        logic [AddrW-1:0] addr;
        logic [2:0]       wdata;
    } mem_req_t;

endpackage

// ===== hw/rtl/gns_grid_mem.sv =====
// Cell grid memory, one port, registered read.
module gns_grid_mem (
    input  logic              clk,
    input  gns_pkg::mem_req_t req,
    output logic [2:0]        rdata
);
    logic [2:0] mem [gns_pkg::Cells];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        rdata <= mem[req.addr];
    end
endmodule

// ===== hw/rtl/grid_neighborhood_satisfaction.sv =====
// Top level: sequencer, shared coordinate/accumulate unit and grid memory.
// Reset clears control, loads default configuration, then clears every cell with busy high.
// From accept to result: write or out of grid end at the check; evaluate splits the location
// by 14 restoring subtract steps, then scans the (2R+1)^2 box, one memory read a cycle.
// Move: reads source and target, refuses on occupancy, else evaluates; moves when satisfied.
// Next word accepted in the cycle its result strobes; the receiver cannot stall.
module grid_neighborhood_satisfaction (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  gns_pkg::item_t   item,
    output logic             done,
    output gns_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [8:0]       cfg_data
);
    localparam int AW = gns_pkg::AddrW;

    gns_pkg::state_t state_reg, state_next;
    logic [7:0]  width_reg, height_reg;
    logic [2:0]  radius_reg;
    logic [8:0]  threshold_reg;
    gns_pkg::item_t item_reg, item_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] quo_reg, quo_next;
    logic [AW-1:0] rem_reg, rem_next;
    logic [3:0]  step_reg, step_next;
    logic [7:0]  cx_reg, cx_next, cy_reg, cy_next;
    logic signed [4:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [2:0]  type_reg, type_next;
    logic [2:0]  src_reg, src_next;
    logic [7:0]  score_reg, score_next;
    logic [6:0]  count_reg, count_next;
    logic        hit_reg, hit_next;
    logic [16:0] lhs_reg, lhs_next, rhs_reg, rhs_next;
    gns_pkg::result_t res_reg, res_next;
    logic        done_reg, done_next;
    gns_pkg::mem_req_t req;
    logic [2:0]  rdata;

    logic [7:0]  w_eff, h_eff;
    logic [2:0]  r_eff;
    logic [14:0] cells;
    logic signed [9:0] nx, ny;
    logic [4:0]  adx, ady;
    logic        in_dia;
    logic [AW:0] trial;

    gns_grid_mem u_mem (.clk(clk), .req(req), .rdata(rdata));

    always_comb
    begin
        w_eff = (width_reg == 8'd0) ? 8'd1 : width_reg;
        h_eff = (height_reg == 8'd0) ? 8'd1 : height_reg;
        r_eff = radius_reg;
        cells = 15'(w_eff) * 15'(h_eff);
        nx = 10'(signed'({2'b0, cx_reg})) + 10'(dx_reg);
        ny = 10'(signed'({2'b0, cy_reg})) + 10'(dy_reg);
        adx = dx_reg[4] ? 5'(-dx_reg) : 5'(dx_reg);
        ady = dy_reg[4] ? 5'(-dy_reg) : 5'(dy_reg);
        in_dia = (6'(adx) + 6'(ady) <= 6'(r_eff)) && !(adx == 5'd0 && ady == 5'd0)
            && !nx[9] && !ny[9] && (nx[7:0] < w_eff) && (ny[7:0] < h_eff)
            && (nx[8] == 1'b0) && (ny[8] == 1'b0);
        trial = {rem_reg, quo_reg[AW-1]} - (AW+1)'({w_eff, 7'b0} >> step_reg);
    end

    assign cfg_ready = (state_reg == gns_pkg::S_IDLE) || (state_reg == gns_pkg::S_CLEAR);
    assign busy = (state_reg != gns_pkg::S_IDLE);
    assign done = done_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gns_pkg::S_CLEAR;
            width_reg     <= 8'd128;
            height_reg    <= 8'd128;
            radius_reg    <= 3'd2;
            threshold_reg <= 9'd128;
            cnt_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    gns_pkg::CFG_WIDTH:
                        width_reg <= (cfg_data[7:0] > 8'(gns_pkg::MaxWidth))
                            ? 8'(gns_pkg::MaxWidth) : cfg_data[7:0];
                    gns_pkg::CFG_HEIGHT:
                        height_reg <= (cfg_data[7:0] > 8'(gns_pkg::MaxHeight))
                            ? 8'(gns_pkg::MaxHeight) : cfg_data[7:0];
                    gns_pkg::CFG_RADIUS:    radius_reg <= cfg_data[2:0];
                    gns_pkg::CFG_THRESHOLD: threshold_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        step_reg  <= step_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        type_reg  <= type_next;
        src_reg   <= src_next;
        score_reg <= score_next;
        count_reg <= count_next;
        hit_reg   <= hit_next;
        lhs_reg   <= lhs_next;
        rhs_reg   <= rhs_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        type_next  = type_reg;
        src_next   = src_reg;
        score_next = score_reg;
        count_next = count_reg;
        hit_next   = 1'b0;
        lhs_next   = lhs_reg;
        rhs_next   = rhs_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        req.we     = 1'b0;
        req.addr   = item_reg.location;
        req.wdata  = '0;
        unique case (state_reg)
            gns_pkg::S_CLEAR:
            begin
                req.we   = 1'b1;
                req.addr = cnt_reg;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == AW'(gns_pkg::Cells - 1))
                begin
                    state_next = gns_pkg::S_IDLE;
                end
            end
            gns_pkg::S_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    res_next   = '0;
                    score_next = '0;
                    count_next = '0;
                    state_next = gns_pkg::S_CHECK;
                end
            end
            gns_pkg::S_CHECK:
            begin
                // range check, then write the cell, pick the location to split, or start the move reads
                if (item_reg.kind == gns_pkg::KIND_WRITE)
                begin
                    if (15'(item_reg.location) >= cells)
                    begin
                        res_next.status = gns_pkg::ST_RANGE;
                    end
                    else
                    begin
                        req.we    = 1'b1;
                        req.wdata = (item_reg.cell_value > 3'(gns_pkg::MaxTypes))
                            ? 3'(gns_pkg::MaxTypes) : item_reg.cell_value;
                    end
                    state_next = gns_pkg::S_DONE;
                end
                else if (item_reg.kind == gns_pkg::KIND_EVAL)
                begin
                    if (15'(item_reg.location) >= cells)
                    begin
                        res_next.status = gns_pkg::ST_RANGE;
                        state_next = gns_pkg::S_DONE;
                    end
                    else
                    begin
                        type_next = item_reg.cell_value;
                        quo_next  = item_reg.location;
                        rem_next  = '0;
                        step_next = '0;
                        state_next = gns_pkg::S_DIV;
                    end
                end
                else if (item_reg.kind == gns_pkg::KIND_MOVE)
                begin
                    if (15'(item_reg.location) >= cells || 15'(item_reg.target) >= cells)
                    begin
                        res_next.status = gns_pkg::ST_RANGE;
                        state_next = gns_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = gns_pkg::S_RDSRC;
                    end
                end
                else
                begin
                    state_next = gns_pkg::S_DONE;
                end
            end
            gns_pkg::S_RDSRC:
            begin
                req.addr   = item_reg.location;
                state_next = gns_pkg::S_WAITSRC;
            end
            gns_pkg::S_WAITSRC:
            begin
                src_next   = rdata;
                req.addr   = item_reg.target;
                state_next = gns_pkg::S_RDTGT;
            end
            gns_pkg::S_RDTGT:
            begin
                req.addr   = item_reg.target;
                state_next = gns_pkg::S_WAITTGT;
            end
            gns_pkg::S_WAITTGT:
            begin
                if (src_reg == 3'd0 || rdata != 3'd0)
                begin
                    res_next.status = gns_pkg::ST_REFUSED;
                    state_next = gns_pkg::S_DONE;
                end
                else
                begin
                    type_next = src_reg;
                    quo_next  = item_reg.target;
                    rem_next  = '0;
                    step_next = '0;
                    state_next = gns_pkg::S_DIV;
                end
            end
            gns_pkg::S_DIV:
            begin
                // one restoring step per cycle: quotient bits shift in from the low end
                // divisor scaled: w << (7-step) compared against rem over low bits
                quo_next = {quo_reg[AW-2:0], 1'b0};
                if (!trial[AW] && ({rem_reg, quo_reg[AW-1]} >= (AW+1)'(w_eff)))
                begin
                    rem_next    = AW'({rem_reg, quo_reg[AW-1]} - (AW+1)'(w_eff));
                    quo_next[0] = 1'b1;
                end
                else
                begin
                    rem_next = AW'({rem_reg, quo_reg[AW-1]});
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 4'(AW - 1))
                begin
                    step_next  = '0;
                    state_next = gns_pkg::S_SCAN;
                    dx_next    = -5'(signed'({2'b0, r_eff}));
                    dy_next    = -5'(signed'({2'b0, r_eff}));
                end
            end
            gns_pkg::S_SCAN:
            begin
                if (step_reg == 4'd0)
                begin
                    cx_next  = rem_reg[7:0];
                    cy_next  = quo_reg[7:0];
                    step_next = 4'd1;
                end
                else
                begin
                    // accumulate previous read, issue next
                    if (hit_reg)
                    begin
                        count_next = count_reg + 1'b1;
                        if (rdata == 3'd0) score_next = score_reg + 8'd1;
                        else if (rdata == type_reg) score_next = score_reg + 8'd2;
                    end
                    hit_next = in_dia;
                    req.addr = AW'(ny[7:0] * w_eff + 16'(nx[7:0]));
                    if (dx_reg == 5'(signed'({2'b0, r_eff})))
                    begin
                        dx_next = -5'(signed'({2'b0, r_eff}));
                        if (dy_reg == 5'(signed'({2'b0, r_eff})))
                        begin
                            state_next = gns_pkg::S_LAST;
                        end
                        dy_next = dy_reg + 5'sd1;
                    end
                    else
                    begin
                        dx_next = dx_reg + 5'sd1;
                    end
                end
            end
            gns_pkg::S_LAST:
            begin
                if (hit_reg)
                begin
                    count_next = count_reg + 1'b1;
                    if (rdata == 3'd0) score_next = score_reg + 8'd1;
                    else if (rdata == type_reg) score_next = score_reg + 8'd2;
                end
                state_next = gns_pkg::S_MULT;
            end
            gns_pkg::S_MULT:
            begin
                lhs_next = {2'b0, score_reg, 7'b0};
                rhs_next = 17'(threshold_reg) * 17'(count_reg);
                state_next = gns_pkg::S_CMP;
            end
            gns_pkg::S_CMP:
            begin
                res_next.score          = score_reg;
                res_next.neighbor_count = count_reg;
                res_next.satisfied      = (lhs_reg >= rhs_reg);
                if (item_reg.kind == gns_pkg::KIND_MOVE)
                begin
                    if (lhs_reg >= rhs_reg)
                    begin
                        req.we    = 1'b1;
                        req.addr  = item_reg.target;
                        req.wdata = type_reg;
                        res_next.moved = 1'b1;
                        state_next = gns_pkg::S_WRMOVE;
                    end
                    else
                    begin
                        res_next.status = gns_pkg::ST_REFUSED;
                        state_next = gns_pkg::S_DONE;
                    end
                end
                else
                begin
                    state_next = gns_pkg::S_DONE;
                end
            end
            gns_pkg::S_WRMOVE:
            begin
                req.we     = 1'b1;
                req.addr   = item_reg.location;
                req.wdata  = '0;
                state_next = gns_pkg::S_DONE;
            end
            gns_pkg::S_DONE:
            begin
                done_next  = 1'b1;
                state_next = gns_pkg::S_IDLE;
            end
            default:
            begin
                state_next = gns_pkg::S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == gns_pkg::S_IDLE) else $error("done outside idle");
    a_moved_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.moved |-> result.status == gns_pkg::ST_OK && result.satisfied)
        else $error("move without satisfaction");
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.neighbor_count <= 7'd112) else $error("count too large");
`endif
endmodule

// ===== bench/tb_grid_neighborhood_satisfaction.sv =====
// Self-checking testbench for the grid neighborhood satisfaction block.
`timescale 1ns / 100ps

module tb_grid_neighborhood_satisfaction;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    gns_pkg::item_t   item;
    logic    done;
    gns_pkg::result_t result;
    logic    cfg_valid;
    logic    cfg_ready;
    logic [1:0] cfg_index;
    logic [8:0] cfg_data;

    grid_neighborhood_satisfaction DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    logic [2:0] grid_copy [gns_pkg::Cells];
    logic [7:0] width_reg;
    logic [7:0] height_reg;
    logic [2:0] radius_reg;
    logic [8:0] threshold_reg;
    gns_pkg::result_t pending_results [$];
    int         error_count;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int cols_in_use();
        if (width_reg == 8'd0) return 1;
        if (int'(width_reg) > gns_pkg::MaxWidth) return gns_pkg::MaxWidth;
        return int'(width_reg);
    endfunction

    function automatic int rows_in_use();
        if (height_reg == 8'd0) return 1;
        if (int'(height_reg) > gns_pkg::MaxHeight) return gns_pkg::MaxHeight;
        return int'(height_reg);
    endfunction

    function automatic void score_site(input int loc, input logic [2:0] kind_of,
                                       inout gns_pkg::result_t res);
        int w, h, r, cx, cy, x, y, span, s, n;
        logic [2:0] c;
        w = cols_in_use();
        h = rows_in_use();
        r = (int'(radius_reg) > gns_pkg::MaxRadius) ? gns_pkg::MaxRadius : int'(radius_reg);
        cx = loc % w;
        cy = loc / w;
        s = 0;
        n = 0;
        for (int dy = -r; dy <= r; dy++)
        begin
            y = cy + dy;
            span = r - ((dy < 0) ? -dy : dy);
            if (y >= 0 && y < h)
                for (int dx = -span; dx <= span; dx++)
                begin
                    x = cx + dx;
                    if (x >= 0 && x < w && !(dx == 0 && dy == 0))
                    begin
                        c = grid_copy[y * w + x];
                        n++;
                        if (c == 3'd0) s += 1;
                        else if (c == kind_of) s += 2;
                    end
                end
        end
        res.score = s[7:0];
        res.neighbor_count = n[6:0];
        res.satisfied = (longint'(s) * 128 >= longint'(threshold_reg) * n);
    endfunction

    function automatic gns_pkg::result_t apply_item(input gns_pkg::item_t it);
        gns_pkg::result_t res;
        int cells;
        logic [2:0] v;
        res = '0;
        cells = cols_in_use() * rows_in_use();
        case (it.kind)
            gns_pkg::KIND_WRITE:
                if (int'(it.location) >= cells) res.status = gns_pkg::ST_RANGE;
                else
                begin
                    v = (int'(it.cell_value) > gns_pkg::MaxTypes)
                        ? 3'(gns_pkg::MaxTypes) : it.cell_value;
                    grid_copy[it.location] = v;
                end
            gns_pkg::KIND_EVAL:
                if (int'(it.location) >= cells) res.status = gns_pkg::ST_RANGE;
                else score_site(int'(it.location), it.cell_value, res);
            gns_pkg::KIND_MOVE:
                if (int'(it.location) >= cells || int'(it.target) >= cells)
                    res.status = gns_pkg::ST_RANGE;
                else if (grid_copy[it.location] == 3'd0 || grid_copy[it.target] != 3'd0)
                    res.status = gns_pkg::ST_REFUSED;
                else
                begin
                    score_site(int'(it.target), grid_copy[it.location], res);
                    if (res.satisfied)
                    begin
                        grid_copy[it.target] = grid_copy[it.location];
                        grid_copy[it.location] = 3'd0;
                        res.moved = 1'b1;
                    end
                    else res.status = gns_pkg::ST_REFUSED;
                end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        gns_pkg::result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected word", 1, 0);
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                    report_mismatch("status", int'(result.status), int'(want.status));
                if (result.moved !== want.moved)
                    report_mismatch("moved", int'(result.moved), int'(want.moved));
                if (result.score !== want.score)
                    report_mismatch("score", int'(result.score), int'(want.score));
                if (result.neighbor_count !== want.neighbor_count)
                    report_mismatch("neighbor_count", int'(result.neighbor_count),
                                    int'(want.neighbor_count));
                if (result.satisfied !== want.satisfied)
                    report_mismatch("satisfied", int'(result.satisfied),
                                    int'(want.satisfied));
            end
        end
    end

    task automatic send_item(input gns_pkg::item_t it, input bit typed,
                             input gns_pkg::result_t typed_res);
        gns_pkg::result_t res;
        int gap;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            item <= '0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        do @(posedge clk); while (busy);
        res = apply_item(it);
        if (typed && res != typed_res)
            report_mismatch("predictor vs table", int'(res), int'(typed_res));
        pending_results = {pending_results, (typed ? typed_res : res)};
    endtask

    task automatic drain();
        start <= 1'b0;
        item <= '0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        unique case (idx)
            gns_pkg::CFG_WIDTH:     width_reg = data[7:0];
            gns_pkg::CFG_HEIGHT:    height_reg = data[7:0];
            gns_pkg::CFG_RADIUS:    radius_reg = data[2:0];
            gns_pkg::CFG_THRESHOLD: threshold_reg = data;
        endcase
    endtask

    function automatic gns_pkg::item_t make_item(input logic [1:0] k, input int loc,
                                                 input int tgt, input logic [2:0] v);
        gns_pkg::item_t it;
        it.kind = k;
        it.location = loc[13:0];
        it.target = tgt[13:0];
        it.cell_value = v;
        return it;
    endfunction

    function automatic gns_pkg::result_t make_result(input logic [1:0] st, input logic mv,
                                                     input int sc, input int cnt,
                                                     input logic sat);
        gns_pkg::result_t res;
        res.status = st;
        res.moved = mv;
        res.score = sc[7:0];
        res.neighbor_count = cnt[6:0];
        res.satisfied = sat;
        return res;
    endfunction

    typedef struct {
        gns_pkg::item_t   it;
        bit               typed;
        gns_pkg::result_t res;
    } stim_row_t;

    stim_row_t directed_rows [$];

    function automatic gns_pkg::item_t random_item(input int cells);
        logic [1:0] k;
        int loc, tgt, pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) k = gns_pkg::KIND_WRITE;
        else if (pick < 60) k = gns_pkg::KIND_EVAL;
        else if (pick < 97) k = gns_pkg::KIND_MOVE;
        else k = gns_pkg::KIND_UNUSED;
        if ($urandom_range(0, 15) == 0)
        begin
            loc = int'($urandom_range(0, 16383));
            tgt = int'($urandom_range(0, 16383));
        end
        else
        begin
            loc = int'($urandom_range(0, cells - 1));
            tgt = int'($urandom_range(0, cells - 1));
        end
        return make_item(k, loc, tgt, 3'($urandom_range(0, 7)));
    endfunction

    initial
    begin
        int cells;
        int phase_w [6];
        int phase_h [6];
        int phase_r [6];
        int phase_t [6];
        phase_w = '{16, 1, 128, 200, 0, 9};
        phase_h = '{16, 128, 1, 255, 12, 7};
        phase_r = '{3, 7, 1, 0, 2, 5};
        phase_t = '{128, 256, 0, 300, 511, 200};
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        width_reg = 8'd128;
        height_reg = 8'd128;
        radius_reg = 3'd2;
        threshold_reg = 9'd128;
        foreach (grid_copy[i]) grid_copy[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_rows = '{
            '{make_item(gns_pkg::KIND_EVAL, 129 * 5, 0, 3'd1), 1'b1,
              make_result(gns_pkg::ST_OK, 1'b0, 12, 12, 1'b1)},
            '{make_item(gns_pkg::KIND_EVAL, 0, 0, 3'd0), 1'b1,
              make_result(gns_pkg::ST_OK, 1'b0, 5, 5, 1'b1)},
            '{make_item(gns_pkg::KIND_EVAL, 16383, 0, 3'd7), 1'b1,
              make_result(gns_pkg::ST_OK, 1'b0, 5, 5, 1'b1)},
            '{make_item(gns_pkg::KIND_WRITE, 16383, 0, 3'd7), 1'b1,
              make_result(gns_pkg::ST_OK, 1'b0, 0, 0, 1'b0)},
            '{make_item(gns_pkg::KIND_WRITE, 16382, 0, 3'd7), 1'b1,
              make_result(gns_pkg::ST_OK, 1'b0, 0, 0, 1'b0)},
            '{make_item(gns_pkg::KIND_WRITE, 0, 0, 3'd3), 1'b1,
              make_result(gns_pkg::ST_OK, 1'b0, 0, 0, 1'b0)},
            '{make_item(gns_pkg::KIND_EVAL, 16383, 0, 3'd7), 1'b0, '0},
            '{make_item(gns_pkg::KIND_EVAL, 16381, 0, 3'd1), 1'b0, '0},
            '{make_item(gns_pkg::KIND_MOVE, 5, 6, 3'd0), 1'b1,
              make_result(gns_pkg::ST_REFUSED, 1'b0, 0, 0, 1'b0)},
            '{make_item(gns_pkg::KIND_MOVE, 0, 16383, 3'd0), 1'b1,
              make_result(gns_pkg::ST_REFUSED, 1'b0, 0, 0, 1'b0)},
            '{make_item(gns_pkg::KIND_MOVE, 0, 0, 3'd0), 1'b1,
              make_result(gns_pkg::ST_REFUSED, 1'b0, 0, 0, 1'b0)},
            '{make_item(gns_pkg::KIND_MOVE, 0, 300, 3'd0), 1'b0, '0},
            '{make_item(gns_pkg::KIND_MOVE, 16383, 1, 3'd0), 1'b0, '0},
            '{make_item(gns_pkg::KIND_UNUSED, 16383, 16383, 3'd7), 1'b1,
              make_result(gns_pkg::ST_OK, 1'b0, 0, 0, 1'b0)},
            '{make_item(gns_pkg::KIND_EVAL, 1, 0, 3'd3), 1'b0, '0}
        };
        foreach (directed_rows[i])
            send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].res);
        drain();

        write_reg(gns_pkg::CFG_WIDTH, 9'd16);
        write_reg(gns_pkg::CFG_HEIGHT, 9'd16);
        write_reg(gns_pkg::CFG_RADIUS, 9'd0);
        write_reg(gns_pkg::CFG_THRESHOLD, 9'd256);
        send_item(make_item(gns_pkg::KIND_EVAL, 17, 0, 3'd1), 1'b1,
                  make_result(gns_pkg::ST_OK, 1'b0, 0, 0, 1'b1));
        send_item(make_item(gns_pkg::KIND_EVAL, 256, 0, 3'd1), 1'b1,
                  make_result(gns_pkg::ST_RANGE, 1'b0, 0, 0, 1'b0));
        send_item(make_item(gns_pkg::KIND_WRITE, 256, 0, 3'd1), 1'b1,
                  make_result(gns_pkg::ST_RANGE, 1'b0, 0, 0, 1'b0));
        send_item(make_item(gns_pkg::KIND_MOVE, 3, 256, 3'd1), 1'b1,
                  make_result(gns_pkg::ST_RANGE, 1'b0, 0, 0, 1'b0));
        send_item(make_item(gns_pkg::KIND_MOVE, 9999, 3, 3'd1), 1'b1,
                  make_result(gns_pkg::ST_RANGE, 1'b0, 0, 0, 1'b0));
        drain();

        for (int p = 0; p < 6; p++)
        begin
            write_reg(gns_pkg::CFG_WIDTH, 9'(phase_w[p]));
            write_reg(gns_pkg::CFG_HEIGHT, 9'(phase_h[p]));
            write_reg(gns_pkg::CFG_RADIUS, 9'(phase_r[p]));
            write_reg(gns_pkg::CFG_THRESHOLD, 9'(phase_t[p]));
            cells = cols_in_use() * rows_in_use();
            for (int n = 0; n < 215; n++)
            begin
                send_item(random_item(cells), 1'b0, '0);
                if (n == 100) drain();
            end
            drain();
        end

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
